[hw/rtl/shg_pkg.sv]
// ----------------------------------------------------------------------------
// shg_pkg
// Shared types, constants and codes for the spatial hash grid radius query.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int COORD_W   = 24;
    localparam int R2_W      = 50;
    localparam int IDX_OUT_W = 15;
    localparam int CELL_W    = 17;
    localparam int INV_W     = 13;
    localparam int PROD_W    = 38;
    localparam int DIST_W    = 52;

    localparam int DEF_TABLE_SLOTS   = 65536;
    localparam int DEF_MAX_POINTS    = 32768;
    localparam int DEF_MAX_NEIGHBORS = 64;
    localparam int DEF_COORD_BITS    = 24;

    localparam logic [INV_W-1:0] INV_RESET = 13'd1024;

    localparam logic [31:0] HASH_KX = 32'd73856093;
    localparam logic [31:0] HASH_KY = 32'd19349663;
    localparam logic [31:0] HASH_KZ = 32'd83492791;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_STORE_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic [R2_W-1:0]         radius_sq;
    } req_t;

    typedef struct packed {
        logic                 has_point;
        logic [IDX_OUT_W-1:0] point_index;
        logic [R2_W-1:0]      dist_sq;
        logic [1:0]           status;
        logic                 truncated;
        logic                 last;
    } res_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_HIT,
        EM_FINAL,
        EM_INSERT,
        EM_TBL_FULL,
        EM_STORE_FULL
    } emit_t;

    typedef struct packed {
        logic  load_req;
        logic  mul_cell;
        logic  load_cell;
        logic  hash_mul;
        logic  hash_fin;
        logic  probe_adv;
        logic  ins_write;
        logic  walk_start;
        logic  sq_mul;
        logic  walk_adv;
        logic  cell_adv;
        logic  sweep_step;
        logic  clr_done;
        logic  set_trunc;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic store_full;
        logic sweep_done;
        logic slot_free;
        logic slot_match;
        logic probe_last;
        logic chain_end;
        logic link_valid;
        logic hit;
        logic cnt_full;
        logic cells_done;
        logic held_valid;
        logic out_free;
    } sts_t;

endpackage

[hw/rtl/spatial_hash_grid_radius_query.sv]
// ----------------------------------------------------------------------------
// spatial_hash_grid_radius_query
// 3D spatial hash grid with linear probing: clear, insert and radius query.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    shg_pkg::req_t
//   res      out        res_valid/stall    shg_pkg::res_t
//   cfg      in         cfg_valid/ready    inv_cell_size
//
// one request at a time; insert computes the cell and hash, then probes slot by slot
// query: per cell a hash, a probe per slot tried and a distance check per chained point
// clear and reset sweep the slot table, one slot a cycle
// a stalled result holds the sequencer only when a further result is due
// ----------------------------------------------------------------------------
module spatial_hash_grid_radius_query #(
    parameter int TABLE_SLOTS   = shg_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_POINTS    = shg_pkg::DEF_MAX_POINTS,
    parameter int MAX_NEIGHBORS = shg_pkg::DEF_MAX_NEIGHBORS,
    parameter int COORD_BITS    = shg_pkg::DEF_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  shg_pkg::req_t             req_item,
    output logic                      res_valid,
    input  logic                      res_stall,
    output shg_pkg::res_t             res_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [shg_pkg::INV_W-1:0] cfg_data
);

    shg_pkg::cmd_t cmd;
    shg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    shg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    shg_datapath #(
        .TABLE_SLOTS   (TABLE_SLOTS),
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_item  (res_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[hw/rtl/shg_ram.sv]
// ----------------------------------------------------------------------------
// shg_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module shg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/shg_datapath.sv]
// ----------------------------------------------------------------------------
// shg_datapath
// Cell and hash arithmetic, slot table, point store, distance unit, results.
// ----------------------------------------------------------------------------
module shg_datapath #(
    parameter int TABLE_SLOTS   = shg_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_POINTS    = shg_pkg::DEF_MAX_POINTS,
    parameter int MAX_NEIGHBORS = shg_pkg::DEF_MAX_NEIGHBORS,
    parameter int COORD_BITS    = shg_pkg::DEF_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shg_pkg::req_t                 req_item,
    input  logic                          cfg_valid,
    input  logic [shg_pkg::INV_W-1:0]     cfg_data,
    input  logic                          res_stall,
    output logic                          res_valid,
    output shg_pkg::res_t                 res_item,
    input  shg_pkg::cmd_t                 cmd,
    output shg_pkg::sts_t                 sts
);

    localparam int CW        = shg_pkg::COORD_W;
    localparam int KW        = shg_pkg::CELL_W;
    localparam int PW        = shg_pkg::PROD_W;
    localparam int DW        = shg_pkg::DIST_W;
    localparam int RW        = shg_pkg::R2_W;
    localparam int OW        = shg_pkg::IDX_OUT_W;
    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int IDX_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS  = $clog2(MAX_NEIGHBORS + 1);
    localparam int SW        = 1 + 3 * KW + IDX_BITS;
    localparam int PTW       = 3 * CW + 1 + IDX_BITS;
    localparam int EW        = CW + 1;

    function automatic logic signed [CW-1:0] sext(input logic [CW-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return CW'(t);
    endfunction

    logic [shg_pkg::INV_W-1:0] inv_reg;
    logic [1:0]                act_reg;
    logic signed [CW-1:0]      x_reg, y_reg, z_reg;
    logic [RW-1:0]             r2_reg;
    logic signed [PW-1:0]      prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [KW-1:0]      qc_x_reg, qc_y_reg, qc_z_reg;
    logic signed [KW-1:0]      tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic signed [1:0]         dx_reg, dy_reg, dz_reg;
    logic [SLOT_BITS-1:0]      hm_x_reg, hm_y_reg, hm_z_reg;
    logic [SLOT_BITS-1:0]      paddr_reg, pcnt_reg, sweep_reg;
    logic [IDX_BITS-1:0]       cur_reg, plink_reg, hidx_reg;
    logic                      plink_v_reg;
    logic [RW-1:0]             sq_x_reg, sq_y_reg, sq_z_reg, hd2_reg;
    logic                      held_v_reg, trunc_reg;
    logic [CNT_BITS-1:0]       cnt_reg;
    logic [IDX_BITS:0]         ps_reg;
    logic                      res_valid_reg;
    shg_pkg::res_t             res_reg;

    logic signed [KW-1:0]      tgt_x, tgt_y, tgt_z;
    logic signed [shg_pkg::INV_W:0] inv_s;
    logic [31:0]               hp_x, hp_y, hp_z;
    logic signed [EW-1:0]      ex, ey, ez;
    logic signed [2*EW-1:0]    e2x, e2y, e2z;
    logic [DW-1:0]             d2;
    logic [IDX_BITS-1:0]       new_idx;

    logic                      slot_we;
    logic [SLOT_BITS-1:0]      slot_waddr;
    logic [SW-1:0]             slot_wdata, slot_rdata;
    logic [PTW-1:0]            pt_wdata, pt_rdata;

    logic                      s_used;
    logic signed [KW-1:0]      s_kx, s_ky, s_kz;
    logic [IDX_BITS-1:0]       s_head;
    logic signed [CW-1:0]      p_x, p_y, p_z;
    logic                      p_lv;
    logic [IDX_BITS-1:0]       p_link;

    logic                      push;
    shg_pkg::res_t             push_data;
    logic                      out_free;

    assign s_used = slot_rdata[SW-1];
    assign s_kx   = slot_rdata[SW-2 -: KW];
    assign s_ky   = slot_rdata[SW-2-KW -: KW];
    assign s_kz   = slot_rdata[SW-2-2*KW -: KW];
    assign s_head = slot_rdata[IDX_BITS-1:0];

    assign p_x    = pt_rdata[PTW-1 -: CW];
    assign p_y    = pt_rdata[PTW-1-CW -: CW];
    assign p_z    = pt_rdata[PTW-1-2*CW -: CW];
    assign p_lv   = pt_rdata[IDX_BITS];
    assign p_link = pt_rdata[IDX_BITS-1:0];

    assign inv_s   = {1'b0, inv_reg};
    assign new_idx = ps_reg[IDX_BITS-1:0];

    assign tgt_x = qc_x_reg + KW'(dx_reg);
    assign tgt_y = qc_y_reg + KW'(dy_reg);
    assign tgt_z = qc_z_reg + KW'(dz_reg);

    assign hp_x = 32'(tgt_x) * shg_pkg::HASH_KX;
    assign hp_y = 32'(tgt_y) * shg_pkg::HASH_KY;
    assign hp_z = 32'(tgt_z) * shg_pkg::HASH_KZ;

    assign ex  = EW'(p_x) - EW'(x_reg);
    assign ey  = EW'(p_y) - EW'(y_reg);
    assign ez  = EW'(p_z) - EW'(z_reg);
    assign e2x = ex * ex;
    assign e2y = ey * ey;
    assign e2z = ez * ez;
    assign d2  = DW'(sq_x_reg) + DW'(sq_y_reg) + DW'(sq_z_reg);

    // slot table: clearing sweep or insert
    assign slot_we    = cmd.sweep_step | cmd.ins_write;
    assign slot_waddr = cmd.sweep_step ? sweep_reg : paddr_reg;
    assign slot_wdata = cmd.sweep_step ? '0 : {1'b1, tgt_x_reg, tgt_y_reg, tgt_z_reg, new_idx};
    assign pt_wdata   = (s_used && !cmd.sweep_step)
                        ? {x_reg, y_reg, z_reg, 1'b1, s_head}
                        : {x_reg, y_reg, z_reg, 1'b0, {IDX_BITS{1'b0}}};

    shg_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (paddr_reg),
        .rdata (slot_rdata)
    );

    shg_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk   (clk),
        .we    (cmd.ins_write),
        .waddr (new_idx),
        .wdata (pt_wdata),
        .raddr (cur_reg),
        .rdata (pt_rdata)
    );

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        push      = 1'b0;
        push_data = '0;
        case (cmd.emit)
            shg_pkg::EM_HIT:
            begin
                push                  = held_v_reg;
                push_data.has_point   = 1'b1;
                push_data.point_index = OW'(hidx_reg);
                push_data.dist_sq     = hd2_reg;
            end
            shg_pkg::EM_FINAL:
            begin
                push                  = 1'b1;
                push_data.has_point   = held_v_reg;
                push_data.point_index = held_v_reg ? OW'(hidx_reg) : '0;
                push_data.dist_sq     = held_v_reg ? hd2_reg : '0;
                push_data.truncated   = trunc_reg;
                push_data.last        = 1'b1;
            end
            shg_pkg::EM_INSERT:
            begin
                push                  = 1'b1;
                push_data.has_point   = 1'b1;
                push_data.point_index = OW'(new_idx);
                push_data.last        = 1'b1;
            end
            shg_pkg::EM_TBL_FULL:
            begin
                push             = 1'b1;
                push_data.status = shg_pkg::ST_TABLE_FULL;
                push_data.last   = 1'b1;
            end
            shg_pkg::EM_STORE_FULL:
            begin
                push             = 1'b1;
                push_data.status = shg_pkg::ST_STORE_FULL;
                push_data.last   = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= shg_pkg::INV_RESET;
            ps_reg        <= '0;
            sweep_reg     <= '0;
            held_v_reg    <= 1'b0;
            trunc_reg     <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                inv_reg <= cfg_data;
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= (sweep_reg == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : sweep_reg + 1'b1;
            end
            if (cmd.clr_done)
            begin
                ps_reg <= '0;
            end
            else if (cmd.ins_write)
            begin
                ps_reg <= ps_reg + 1'b1;
            end
            if (cmd.load_cell)
            begin
                held_v_reg <= 1'b0;
                trunc_reg  <= 1'b0;
                cnt_reg    <= '0;
            end
            else if (cmd.emit == shg_pkg::EM_HIT)
            begin
                held_v_reg <= 1'b1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            else if (cmd.emit == shg_pkg::EM_FINAL)
            begin
                held_v_reg <= 1'b0;
                trunc_reg  <= 1'b0;
            end
            else if (cmd.set_trunc)
            begin
                trunc_reg <= 1'b1;
            end
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            act_reg <= req_item.action;
            x_reg   <= sext(req_item.x_coord);
            y_reg   <= sext(req_item.y_coord);
            z_reg   <= sext(req_item.z_coord);
            r2_reg  <= req_item.radius_sq;
        end
        if (cmd.mul_cell)
        begin
            prod_x_reg <= PW'(x_reg) * PW'(inv_s);
            prod_y_reg <= PW'(y_reg) * PW'(inv_s);
            prod_z_reg <= PW'(z_reg) * PW'(inv_s);
        end
        if (cmd.load_cell)
        begin
            qc_x_reg <= prod_x_reg[PW-2 -: KW];
            qc_y_reg <= prod_y_reg[PW-2 -: KW];
            qc_z_reg <= prod_z_reg[PW-2 -: KW];
            dx_reg   <= (act_reg == shg_pkg::ACT_QUERY) ? 2'sb11 : 2'sb00;
            dy_reg   <= (act_reg == shg_pkg::ACT_QUERY) ? 2'sb11 : 2'sb00;
            dz_reg   <= (act_reg == shg_pkg::ACT_QUERY) ? 2'sb11 : 2'sb00;
        end
        else if (cmd.cell_adv)
        begin
            if (dx_reg != 2'sb01)
            begin
                dx_reg <= dx_reg + 2'sb01;
            end
            else
            begin
                dx_reg <= 2'sb11;
                if (dy_reg != 2'sb01)
                begin
                    dy_reg <= dy_reg + 2'sb01;
                end
                else
                begin
                    dy_reg <= 2'sb11;
                    dz_reg <= dz_reg + 2'sb01;
                end
            end
        end
        if (cmd.hash_mul)
        begin
            tgt_x_reg <= tgt_x;
            tgt_y_reg <= tgt_y;
            tgt_z_reg <= tgt_z;
            hm_x_reg  <= hp_x[SLOT_BITS-1:0];
            hm_y_reg  <= hp_y[SLOT_BITS-1:0];
            hm_z_reg  <= hp_z[SLOT_BITS-1:0];
        end
        if (cmd.hash_fin)
        begin
            paddr_reg <= hm_x_reg ^ hm_y_reg ^ hm_z_reg;
            pcnt_reg  <= '0;
        end
        else if (cmd.probe_adv)
        begin
            paddr_reg <= (paddr_reg == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : paddr_reg + 1'b1;
            pcnt_reg  <= pcnt_reg + 1'b1;
        end
        if (cmd.walk_start)
        begin
            cur_reg <= s_head;
        end
        else if (cmd.walk_adv)
        begin
            cur_reg <= plink_reg;
        end
        if (cmd.sq_mul)
        begin
            sq_x_reg    <= RW'(e2x);
            sq_y_reg    <= RW'(e2y);
            sq_z_reg    <= RW'(e2z);
            plink_reg   <= p_link;
            plink_v_reg <= p_lv;
        end
        if (cmd.emit == shg_pkg::EM_HIT)
        begin
            hidx_reg <= cur_reg;
            hd2_reg  <= d2[RW-1:0];
        end
        if (push)
        begin
            res_reg <= push_data;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    assign sts.act        = act_reg;
    assign sts.store_full = (ps_reg == (IDX_BITS+1)'(MAX_POINTS));
    assign sts.sweep_done = (sweep_reg == SLOT_BITS'(TABLE_SLOTS - 1));
    assign sts.slot_free  = !s_used;
    assign sts.slot_match = s_used && (s_kx == tgt_x_reg) && (s_ky == tgt_y_reg)
                            && (s_kz == tgt_z_reg);
    assign sts.probe_last = (pcnt_reg == SLOT_BITS'(TABLE_SLOTS - 1));
    assign sts.chain_end  = ({1'b0, cur_reg} >= ps_reg);
    assign sts.link_valid = plink_v_reg;
    assign sts.hit        = (d2 <= DW'(r2_reg));
    assign sts.cnt_full   = (cnt_reg == CNT_BITS'(MAX_NEIGHBORS));
    assign sts.cells_done = (dx_reg == 2'sb01) && (dy_reg == 2'sb01) && (dz_reg == 2'sb01);
    assign sts.held_valid = held_v_reg;
    assign sts.out_free   = out_free;

endmodule

[hw/rtl/shg_ctrl.sv]
// ----------------------------------------------------------------------------
// shg_ctrl
// Sequencer for clear, insert with probing, and the 27-cell radius walk.
// ----------------------------------------------------------------------------
module shg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  shg_pkg::sts_t sts,
    output shg_pkg::cmd_t cmd
);

    typedef enum logic [14:0] {
        S_INIT  = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_DISP  = 15'b000000000000100,
        S_SFULL = 15'b000000000001000,
        S_CELL  = 15'b000000000010000,
        S_H1    = 15'b000000000100000,
        S_H2    = 15'b000000001000000,
        S_PRD   = 15'b000000010000000,
        S_PCHK  = 15'b000000100000000,
        S_WCHK  = 15'b000001000000000,
        S_WSQ   = 15'b000010000000000,
        S_WSUM  = 15'b000100000000000,
        S_NEXT  = 15'b001000000000000,
        S_FIN   = 15'b010000000000000,
        S_CLR   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = shg_pkg::EM_NONE;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.mul_cell = 1'b1;
                case (sts.act)
                    shg_pkg::ACT_CLEAR:  state_next = S_CLR;
                    shg_pkg::ACT_INSERT: state_next = sts.store_full ? S_SFULL : S_CELL;
                    shg_pkg::ACT_QUERY:  state_next = S_CELL;
                    default:             state_next = S_IDLE;
                endcase
            end
            S_SFULL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = shg_pkg::EM_STORE_FULL;
                    state_next = S_IDLE;
                end
            end
            S_CELL:
            begin
                cmd.load_cell = 1'b1;
                state_next    = S_H1;
            end
            S_H1:
            begin
                cmd.hash_mul = 1'b1;
                state_next   = S_H2;
            end
            S_H2:
            begin
                cmd.hash_fin = 1'b1;
                state_next   = S_PRD;
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (sts.act == shg_pkg::ACT_INSERT)
                begin
                    if (sts.slot_free || sts.slot_match)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.ins_write = 1'b1;
                            cmd.emit      = shg_pkg::EM_INSERT;
                            state_next    = S_IDLE;
                        end
                    end
                    else if (sts.probe_last)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = shg_pkg::EM_TBL_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.probe_adv = 1'b1;
                        state_next    = S_PRD;
                    end
                end
                else
                begin
                    if (sts.slot_match)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WCHK;
                    end
                    else if (sts.slot_free || sts.probe_last)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        cmd.probe_adv = 1'b1;
                        state_next    = S_PRD;
                    end
                end
            end
            S_WCHK:
            begin
                state_next = sts.chain_end ? S_NEXT : S_WSQ;
            end
            S_WSQ:
            begin
                cmd.sq_mul = 1'b1;
                state_next = S_WSUM;
            end
            S_WSUM:
            begin
                if (sts.hit && sts.cnt_full)
                begin
                    cmd.set_trunc = 1'b1;
                    state_next    = S_FIN;
                end
                else if (!sts.hit || !sts.held_valid || sts.out_free)
                begin
                    if (sts.hit)
                    begin
                        cmd.emit = shg_pkg::EM_HIT;
                    end
                    if (sts.link_valid)
                    begin
                        cmd.walk_adv = 1'b1;
                        state_next   = S_WCHK;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                if (sts.cells_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.cell_adv = 1'b1;
                    state_next   = S_H1;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = shg_pkg::EM_FINAL;
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    cmd.clr_done = 1'b1;
                    state_next   = S_FIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the spatial hash grid radius query. A scoreboard predicts the
// results of every accepted request (clear, insert, radius query) from its own
// copy of the grid and checks them in order. Directed requests cover the
// coordinate extremes, chaining and empty queries; random phases run clustered
// points under several cell sizes, and a final clear restarts an empty grid.
// ----------------------------------------------------------------------------
module tb_top;
    import shg_pkg::*;

    localparam int TS = DEF_TABLE_SLOTS;
    localparam int MP = DEF_MAX_POINTS;
    localparam int MN = DEF_MAX_NEIGHBORS;
    localparam int IDLE_LIMIT = 300000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    class grid_scoreboard;
        bit              used[TS];
        int              kx[TS], ky[TS], kz[TS];
        int unsigned     head[TS];
        int              sx[MP], sy[MP], sz[MP];
        int unsigned     link[MP];
        bit              link_ok[MP];
        int unsigned     npoints;
        logic [INV_W-1:0] inv;
        res_t            pending[$];
        int              errors;

        function new();
            inv = INV_RESET;
            npoints = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void queue_result(res_t r);
            pending = {pending, r};
        endfunction

        function int cell_of(int c);
            longint p;
            p = longint'(c) * longint'({1'b0, inv});
            return int'(p >>> 20);
        endfunction

        function int find_slot(int cx, int cy, int cz);
            logic [63:0] h;
            int unsigned s;
            h = (64'(longint'(cx)) * 64'd73856093) ^ (64'(longint'(cy)) * 64'd19349663) ^
                (64'(longint'(cz)) * 64'd83492791);
            s = int'(h % TS);
            for (int n = 0; n < TS; n++)
            begin
                if (!used[s] || (kx[s] == cx && ky[s] == cy && kz[s] == cz))
                    return s;
                s = (s + 1) % TS;
            end
            return -1;
        endfunction

        function res_t blank();
            res_t r;
            r = '0;
            r.last = 1'b1;
            return r;
        endfunction

        function void note(req_t q);
            int x, y, z, cx, cy, cz, s;
            int unsigned cur, steps;
            bit more, trunc;
            longint ex, ey, ez, d2;
            res_t r;
            res_t hits[$];
            x = q.x_coord;
            y = q.y_coord;
            z = q.z_coord;
            case (q.action)
                ACT_CLEAR:
                begin
                    for (int i = 0; i < TS; i++)
                        used[i] = 1'b0;
                    npoints = 0;
                    queue_result(blank());
                end
                ACT_INSERT:
                begin
                    r = blank();
                    cx = cell_of(x);
                    cy = cell_of(y);
                    cz = cell_of(z);
                    s = (npoints >= MP) ? -1 : find_slot(cx, cy, cz);
                    if (npoints >= MP)
                        r.status = ST_STORE_FULL;
                    else if (s < 0)
                        r.status = ST_TABLE_FULL;
                    else
                    begin
                        sx[npoints] = x;
                        sy[npoints] = y;
                        sz[npoints] = z;
                        link_ok[npoints] = used[s];
                        link[npoints] = used[s] ? head[s] : 0;
                        if (!used[s])
                        begin
                            used[s] = 1'b1;
                            kx[s] = cx;
                            ky[s] = cy;
                            kz[s] = cz;
                        end
                        head[s] = npoints;
                        r.has_point = 1'b1;
                        r.point_index = npoints[IDX_OUT_W-1:0];
                        npoints++;
                    end
                    queue_result(r);
                end
                ACT_QUERY:
                begin
                    trunc = 1'b0;
                    cx = cell_of(x);
                    cy = cell_of(y);
                    cz = cell_of(z);
                    for (int dz = -1; dz <= 1; dz++)
                        for (int dy = -1; dy <= 1; dy++)
                            for (int dx = -1; dx <= 1; dx++)
                            begin
                                if (trunc)
                                    continue;
                                s = find_slot(cx + dx, cy + dy, cz + dz);
                                if (s < 0 || !used[s])
                                    continue;
                                cur = head[s];
                                more = 1'b1;
                                steps = 0;
                                while (more && steps < MP && cur < npoints)
                                begin
                                    ex = longint'(sx[cur]) - x;
                                    ey = longint'(sy[cur]) - y;
                                    ez = longint'(sz[cur]) - z;
                                    d2 = ex * ex + ey * ey + ez * ez;
                                    if (d2 <= longint'({14'd0, q.radius_sq}))
                                    begin
                                        if (hits.size() >= MN)
                                        begin
                                            trunc = 1'b1;
                                            break;
                                        end
                                        r = '0;
                                        r.has_point = 1'b1;
                                        r.point_index = cur[IDX_OUT_W-1:0];
                                        r.dist_sq = d2[R2_W-1:0];
                                        hits = {hits, r};
                                    end
                                    more = link_ok[cur];
                                    cur = link[cur];
                                    steps++;
                                end
                            end
                    if (hits.size() == 0)
                        queue_result(blank());
                    else
                    begin
                        hits[hits.size()-1].truncated = trunc;
                        hits[hits.size()-1].last = 1'b1;
                        foreach (hits[i])
                            queue_result(hits[i]);
                    end
                end
                default: ;
            endcase
        endfunction

        task check(res_t got);
            res_t e;
            if (pending.size() == 0)
            begin
                report("result with none expected");
                return;
            end
            e = pending.pop_front();
            if (got.has_point !== e.has_point)
                report($sformatf("has_point %0b, expected %0b", got.has_point, e.has_point));
            if (got.point_index !== e.point_index)
                report($sformatf("point_index %0d, expected %0d", got.point_index,
                                 e.point_index));
            if (got.dist_sq !== e.dist_sq)
                report($sformatf("dist_sq %0d, expected %0d", got.dist_sq, e.dist_sq));
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.truncated !== e.truncated)
                report($sformatf("truncated %0b, expected %0b", got.truncated, e.truncated));
            if (got.last !== e.last)
                report($sformatf("last %0b, expected %0b", got.last, e.last));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    req_t             req_item;
    logic             res_valid;
    logic             res_stall;
    res_t             res_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [INV_W-1:0] cfg_data;

    grid_scoreboard sb = new();
    int  burst_left;
    int  hold_reqs;
    int  hold_seen;
    int  hold_cnt;
    int  stall_mode;
    int  stall_timer;
    int  idle_cycles;
    int  cx0, cy0, cz0, span;

    spatial_hash_grid_radius_query u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note(req_item);
            if (res_valid && !res_stall)
                sb.check(res_item);
            if (cfg_valid && cfg_ready)
                sb.inv = cfg_data;
        end
    end

    // receiver stall pattern, with a long hold-off on demand
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_seen <= 0;
            hold_cnt <= 0;
            stall_mode <= 0;
            stall_timer <= 0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_cnt <= 500;
            res_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_timer <= $urandom_range(20, 120);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 9) < 3);
                default: res_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task send_request(logic [1:0] act, int x, int y, int z, logic [R2_W-1:0] r2);
        req_t r;
        int gap;
        r.action = act;
        r.x_coord = x[COORD_W-1:0];
        r.y_coord = y[COORD_W-1:0];
        r.z_coord = z[COORD_W-1:0];
        r.radius_sq = r2;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        req_valid <= 1'b1;
        req_item <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task write_cell_size(logic [INV_W-1:0] v);
        wait_drained();
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        span = (3 << 20) / v;
        if (span > (1 << 22))
            span = 1 << 22;
        if (span < 64)
            span = 64;
        cx0 = $urandom_range(0, 1 << 23) - (1 << 22);
        cy0 = $urandom_range(0, 1 << 23) - (1 << 22);
        cz0 = $urandom_range(0, 1 << 23) - (1 << 22);
    endtask

    function int near_coord(int c0);
        return c0 + $urandom_range(0, 2 * span) - span;
    endfunction

    task random_request();
        int pick, rad, x, y, z;
        logic [R2_W-1:0] r2;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            x = $urandom();
            y = $urandom();
            z = $urandom();
        end
        else
        begin
            x = near_coord(cx0);
            y = near_coord(cy0);
            z = near_coord(cz0);
        end
        rad = $urandom_range(0, span);
        case ($urandom_range(0, 9))
            0: r2 = R2_W'({$urandom(), $urandom()});
            1: r2 = '1;
            default: r2 = R2_W'(longint'(rad) * rad);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_request(ACT_UNUSED, x, y, z, r2);
        else if (pick < 52)
            send_request(ACT_INSERT, x, y, z, r2);
        else
            send_request(ACT_QUERY, x, y, z, r2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        cfg_valid = 1'b0;
        cfg_data = INV_RESET;
        hold_reqs = 0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests under the reset cell size
        write_cell_size(13'd1024);
        send_request(ACT_QUERY, 0, 0, 0, '1);
        send_request(ACT_INSERT, 8388607, 8388607, 8388607, '0);
        send_request(ACT_INSERT, -8388608, -8388608, -8388608, '0);
        send_request(ACT_INSERT, 0, 0, 0, '0);
        send_request(ACT_INSERT, 100, 200, 300, '0);
        send_request(ACT_INSERT, -1, -1, -1, '0);
        send_request(ACT_INSERT, 1024, 0, -1024, '0);
        send_request(ACT_QUERY, 0, 0, 0, '0);
        send_request(ACT_QUERY, 0, 0, 0, '1);
        send_request(ACT_QUERY, 50, 100, 150, 50'd200000);
        send_request(ACT_QUERY, 4000000, 0, 0, '1);
        send_request(ACT_QUERY, 8388607, 8388607, 8388607, '0);
        send_request(ACT_QUERY, -8388608, -8388608, -8388608, '1);
        send_request(ACT_UNUSED, 5, 5, 5, '1);
        send_request(ACT_CLEAR, 0, 0, 0, '0);
        send_request(ACT_QUERY, 0, 0, 0, '1);
        send_request(ACT_INSERT, 7, 7, 7, '0);
        send_request(ACT_QUERY, 7, 7, 7, '0);

        write_cell_size(13'd1024);
        repeat (50) random_request();
        write_cell_size(13'd4096);
        repeat (50) random_request();
        write_cell_size(13'd1);
        repeat (20) random_request();
        hold_reqs <= hold_reqs + 1;
        repeat (60) random_request();
        wait_drained();
        write_cell_size(13'd255);
        repeat (40) random_request();
        write_cell_size(13'($urandom_range(2, 4095)));
        repeat (30) random_request();

        // clear and restart on an empty grid
        write_cell_size(13'd1024);
        send_request(ACT_CLEAR, 0, 0, 0, '0);
        send_request(ACT_INSERT, 3, 3, 3, '0);
        send_request(ACT_QUERY, 3, 3, 3, '1);
        send_request(ACT_CLEAR, 0, 0, 0, '0);

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/shg_pkg.sv
hw/rtl/shg_ram.sv
hw/rtl/shg_datapath.sv
hw/rtl/shg_ctrl.sv
hw/rtl/spatial_hash_grid_radius_query.sv
test/tb_top.sv
